// File: rtl/periodic_task_dispatcher_top_assert.svh
// Assertion macros used by the dispatcher top-level RTL.
`ifndef PERIODIC_TASK_DISPATCHER_TOP_ASSERT_SVH
`define PERIODIC_TASK_DISPATCHER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptd: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptd: next-cycle check failed");

`endif

// File: rtl/ptd_pkg.sv
package ptd_pkg;

    localparam int NUM_TASKS_DEF  = 8;
    localparam int TIME_WIDTH_DEF = 16;

    localparam int FIELD_W     = 16;   // interval/phase field pitch in a config word
    localparam int COUNT_W     = 18;   // signed elapsed counter
    localparam int DT_W        = 10;   // clamped tick
    localparam int DELTA_W     = 12;
    localparam int SLOT_W      = 3;
    localparam int PRIO_W      = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [DELTA_W-1:0] TICK_CLAMP = DELTA_W'(800);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = COUNT_W'(131071);
    localparam logic [PRIO_W-1:0]  NO_PRIO    = PRIO_W'(8);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INTERVAL_LO = 3'd0,
        REG_INTERVAL_HI = 3'd1,
        REG_PHASE_LO    = 3'd2,
        REG_PHASE_HI    = 3'd3,
        REG_HEAVY_MASK  = 3'd4,
        REG_PRIORITY    = 3'd5
    } t_cfg_reg;

    typedef logic signed [COUNT_W-1:0] t_count;

    typedef struct packed {
        logic advance;     // tick accepted: advance enabled counters
        logic prio;        // fire priority slot if due, clear heavy pick
        logic heavy_step;  // examine one slot for the heavy pick
        logic mark;        // build the pending mask and zero fired counters
        logic emit;        // load next result into the output register
    } t_cmd;

    typedef struct packed {
        logic out_free;    // output register empty or being taken
        logic emit_last;   // next result closes the tick
    } t_status;

endpackage

// File: rtl/ptd_ctrl.sv
module ptd_ctrl #(
    parameter int NUM_TASKS = ptd_pkg::NUM_TASKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ptd_pkg::t_status  i_status,
    output ptd_pkg::t_cmd     o_cmd,
    output logic [((NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1)-1:0] o_idx
);
    import ptd_pkg::*;

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIO,
        ST_HEAVY,
        ST_MARK,
        ST_EMIT
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) r_state <= ST_PRIO;
                end
                ST_PRIO: begin
                    r_idx   <= '0;
                    r_state <= ST_HEAVY;
                end
                ST_HEAVY: begin
                    if (r_idx == LAST_IDX) begin
                        r_state <= ST_MARK;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_MARK: begin
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (i_status.out_free && i_status.emit_last) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        o_in_ready       = (r_state == ST_IDLE);
        o_cmd            = '0;
        o_cmd.advance    = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.prio       = (r_state == ST_PRIO);
        o_cmd.heavy_step = (r_state == ST_HEAVY);
        o_cmd.mark       = (r_state == ST_MARK);
        o_cmd.emit       = (r_state == ST_EMIT) && i_status.out_free;
    end

    assign o_idx = r_idx;

endmodule

// File: rtl/ptd_datapath.sv
module ptd_datapath #(
    parameter int NUM_TASKS  = ptd_pkg::NUM_TASKS_DEF,
    parameter int TIME_WIDTH = ptd_pkg::TIME_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ptd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ptd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [ptd_pkg::DELTA_W-1:0]         i_delta,
    input  ptd_pkg::t_cmd                       i_cmd,
    input  logic [((NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1)-1:0] i_idx,
    output ptd_pkg::t_status                    o_status,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [ptd_pkg::SLOT_W-1:0]          o_run_slot,
    output logic                                o_run_valid,
    output logic                                o_last
);
    import ptd_pkg::*;

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int EXT_W = COUNT_W - TIME_WIDTH;

    logic [TIME_WIDTH-1:0] r_iv [NUM_TASKS];
    t_count                r_count [NUM_TASKS];
    logic [NUM_TASKS-1:0]  r_heavy;
    logic [PRIO_W-1:0]     r_prio;

    logic                  r_pick_valid;
    logic [IDX_W-1:0]      r_pick;
    logic [COUNT_W-2:0]    r_best;

    logic                  r_prio_pend;
    logic [NUM_TASKS-1:0]  r_pend;

    logic                  r_out_valid;
    logic [SLOT_W-1:0]     r_out_slot;
    logic                  r_out_run;
    logic                  r_out_last;

    logic [DT_W-1:0]       w_dt;
    logic [NUM_TASKS-1:0]  w_due;
    logic [NUM_TASKS-1:0]  w_prio_oh;
    logic [NUM_TASKS-1:0]  w_pick_oh;
    logic [NUM_TASKS-1:0]  w_pend_next;
    logic [NUM_TASKS-1:0]  w_zero;
    logic                  w_prio_fire;

    // clamp long ticks
    assign w_dt = (i_delta > TICK_CLAMP) ? DT_W'(TICK_CLAMP) : i_delta[DT_W-1:0];

    // per-slot interval, counter and due flag
    for (genvar s = 0; s < NUM_TASKS; s++) begin : g_slot
        localparam t_cfg_reg IV_REG = t_cfg_reg'((s < 4) ? REG_INTERVAL_LO : REG_INTERVAL_HI);
        localparam t_cfg_reg PH_REG = t_cfg_reg'((s < 4) ? REG_PHASE_LO : REG_PHASE_HI);
        localparam int       OFS    = (s % 4) * FIELD_W;

        logic signed [COUNT_W:0] w_sum;
        logic                    w_sat;
        logic                    w_phase_we;

        assign w_phase_we = i_cfg_we && (i_cfg_idx == PH_REG);
        assign w_sum = $signed({r_count[s][COUNT_W-1], r_count[s]})
                     + $signed({{(COUNT_W + 1 - DT_W){1'b0}}, w_dt});
        assign w_sat = !w_sum[COUNT_W] && w_sum[COUNT_W-1];

        assign w_due[s] = (r_iv[s] != '0)
                       && (r_count[s] >= $signed({{EXT_W{1'b0}}, r_iv[s]}));
        assign w_prio_oh[s] = (r_prio == PRIO_W'(s));
        assign w_pick_oh[s] = r_pick_valid && (r_pick == IDX_W'(s));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_iv[s] <= '0;
            end else if (i_cfg_we && (i_cfg_idx == IV_REG)) begin
                r_iv[s] <= i_cfg_data[OFS +: TIME_WIDTH];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_count[s] <= '0;
            end else if (w_phase_we) begin
                r_count[s] <= t_count'('0) - $signed({{EXT_W{1'b0}},
                                                      i_cfg_data[OFS +: TIME_WIDTH]});
            end else if (i_cmd.advance && (r_iv[s] != '0)) begin
                r_count[s] <= w_sat ? $signed(COUNT_MAX) : w_sum[COUNT_W-1:0];
            end else if (w_zero[s]) begin
                r_count[s] <= '0;
            end
        end
    end

    // priority slot values of NUM_TASKS or more never match a slot
    assign w_prio_fire = |(w_prio_oh & w_due);
    assign w_pend_next = w_due & ~w_prio_oh & (~r_heavy | w_pick_oh);
    assign w_zero      = ({NUM_TASKS{i_cmd.prio}} & w_prio_oh & w_due)
                       | ({NUM_TASKS{i_cmd.mark}} & w_pend_next);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heavy <= '0;
            r_prio  <= NO_PRIO;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HEAVY_MASK: r_heavy <= i_cfg_data[NUM_TASKS-1:0];
                REG_PRIORITY:   r_prio  <= i_cfg_data[PRIO_W-1:0];
                default:        ;
            endcase
        end
    end

    // heavy pick: most overdue, lowest slot on ties
    logic                    w_cand;
    logic signed [COUNT_W-1:0] w_over;

    assign w_cand = r_heavy[i_idx] && w_due[i_idx];
    assign w_over = r_count[i_idx] - $signed({{EXT_W{1'b0}}, r_iv[i_idx]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pick_valid <= 1'b0;
        end else if (i_cmd.prio) begin
            r_pick_valid <= 1'b0;
        end else if (i_cmd.heavy_step && w_cand
                     && (!r_pick_valid || (w_over[COUNT_W-2:0] > r_best))) begin
            r_pick_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.heavy_step && w_cand
            && (!r_pick_valid || (w_over[COUNT_W-2:0] > r_best))) begin
            r_pick <= i_idx;
            r_best <= w_over[COUNT_W-2:0];
        end
    end

    // result sequencing
    logic [IDX_W-1:0]     w_low_idx;
    logic [NUM_TASKS-1:0] w_low_oh;
    logic                 w_has;
    logic [SLOT_W-1:0]    w_slot;
    logic                 w_run;
    logic                 w_last;

    always_comb begin
        w_low_idx = '0;
        for (int s = NUM_TASKS - 1; s >= 0; s--) begin
            if (r_pend[s]) w_low_idx = IDX_W'(s);
        end
    end

    assign w_low_oh = r_pend & (~r_pend + 1'b1);
    assign w_has    = |r_pend;

    always_comb begin
        priority if (r_prio_pend) begin
            w_slot = SLOT_W'(r_prio);
            w_run  = 1'b1;
            w_last = !w_has;
        end else if (w_has) begin
            w_slot = SLOT_W'(w_low_idx);
            w_run  = 1'b1;
            w_last = ((r_pend & ~w_low_oh) == '0);
        end else begin
            w_slot = '0;
            w_run  = 1'b0;
            w_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio_pend <= 1'b0;
            r_pend      <= '0;
        end else if (i_cmd.prio) begin
            r_prio_pend <= w_prio_fire;
        end else if (i_cmd.mark) begin
            r_pend <= w_pend_next;
        end else if (i_cmd.emit) begin
            if (r_prio_pend) begin
                r_prio_pend <= 1'b0;
            end else begin
                r_pend <= r_pend & ~w_low_oh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_slot <= w_slot;
            r_out_run  <= w_run;
            r_out_last <= w_last;
        end
    end

    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.emit_last = w_last;

    assign o_out_valid = r_out_valid;
    assign o_run_slot  = r_out_slot;
    assign o_run_valid = r_out_run;
    assign o_last      = r_out_last;

endmodule

// File: rtl/periodic_task_dispatcher_top.sv
// Channel    Dir  Handshake                   Payload (lowest bit first)
// s_axis     in   tvalid/tready               tdata: delta_time[11:0], zero pad to 16
// m_axis     out  tvalid/tready               tdata: run_slot[2:0], zero pad to 8;
//                                             tuser: run_valid; tlast: last_of_tick
// cfg        in   i_cfg_we (no wait)          i_cfg_idx register index, i_cfg_data
//
// Each tick steps through the priority check, a slot-by-slot heavy scan through a single
// overdue comparator, the mark step and one emit per result (at least one) into the single
// output register, so a result is emitted only while that register is free.
// Synchronous active-low reset; counters and config registers clear, priority slot reads
// as none. A stalled output holds the sequencer in its emit step; the next tick is taken
// once the last result of a tick sits in the output register, even before it is taken.
`include "periodic_task_dispatcher_top_assert.svh"

module periodic_task_dispatcher_top #(
    parameter int NUM_TASKS  = ptd_pkg::NUM_TASKS_DEF,
    parameter int TIME_WIDTH = ptd_pkg::TIME_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tick stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,   // delta_time[11:0]
    // dispatch stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // run_slot[2:0]
    output logic [0:0]                      m_axis_tuser,   // run_valid
    output logic                            m_axis_tlast,   // last_of_tick
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [ptd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ptd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ptd_pkg::*;

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    t_cmd              w_cmd;
    t_status           w_status;
    logic [IDX_W-1:0]  w_idx;
    logic [SLOT_W-1:0] w_run_slot;
    logic              w_in_acc;

    // sequencer: accept tick, priority check, heavy scan, mark, emit
    ptd_ctrl #(
        .NUM_TASKS (NUM_TASKS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx)
    );

    // counters, config registers, pick logic and output register
    ptd_datapath #(
        .NUM_TASKS  (NUM_TASKS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_delta     (s_axis_tdata[DELTA_W-1:0]),
        .i_cmd       (w_cmd),
        .i_idx       (w_idx),
        .o_status    (w_status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_run_slot  (w_run_slot),
        .o_run_valid (m_axis_tuser[0]),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {{(8 - SLOT_W){1'b0}}, w_run_slot};
    assign w_in_acc     = s_axis_tvalid && s_axis_tready;

    // a taken tick drops ready until its results are sequenced
    `PTD_ASSERT_NEXT(a_busy_after_tick, i_clk, i_rst_n, w_in_acc, !s_axis_tready)
    // an empty result always closes its tick
    `PTD_ASSERT_SAME(a_empty_is_last, i_clk, i_rst_n,
                     m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast)
    // results of one tick follow without a gap
    `PTD_ASSERT_NEXT(a_no_gap, i_clk, i_rst_n,
                     m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)
    // no new tick while a tick is still mid-sequence
    `PTD_ASSERT_SAME(a_no_tick_mid_burst, i_clk, i_rst_n,
                     m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

endmodule
